>>> design/set_associative_cache_controller_unit_macros.svh
// Assertion macros for the set-associative cache controller.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SET_ASSOCIATIVE_CACHE_CONTROLLER_UNIT_MACROS_SVH
`define SET_ASSOCIATIVE_CACHE_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define SACC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SACC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/sacc_pkg.sv
// Shared types and constants of the set-associative cache controller.
// No dependencies; imported by the interfaces and by every module but sacc_row_ram.
`default_nettype none

package sacc_pkg;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int CYC_W      = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;
  localparam int IDX_FLD_W  = 15;

  localparam int MEM_CYCLES  = 100;
  localparam int WORD_BYTES  = 4;
  localparam int BLOCK_UNIT  = MEM_CYCLES / WORD_BYTES;

  localparam logic [3:0] OFFSET_MAX = 4'd12;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_STORE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LRU_MODE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_THROUGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_ON_WR   = 3'd5;

  typedef struct packed {
    logic [3:0] offset_bits;
    logic [3:0] index_bits;
    logic [2:0] ways_in_use;
    logic       lru_mode;
    logic       write_through_mode;
    logic       allocate_on_write;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    offset_bits:        4'd4,
    index_bits:         4'd8,
    ways_in_use:        3'd4,
    lru_mode:           1'b1,
    write_through_mode: 1'b0,
    allocate_on_write:  1'b1
  };

endpackage

`default_nettype wire

>>> design/sacc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on sacc_pkg.
`default_nettype none

interface sacc_cfg_if import sacc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

>>> design/sacc_req_if.sv
// Access request channel: load or store command and byte address.
// Depends on sacc_pkg.
`default_nettype none

interface sacc_req_if import sacc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

`default_nettype wire

>>> design/sacc_rsp_if.sv
// Access result channel: hit, victim write-back, fill and cycle cost.
// Depends on sacc_pkg.
`default_nettype none

interface sacc_rsp_if import sacc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic             dirty_evicted;
  logic             allocated;
  logic [CYC_W-1:0] cycles_charged;

  modport source (output valid, output hit, output dirty_evicted, output allocated,
                  output cycles_charged, input ready);
  modport sink   (input valid, input hit, input dirty_evicted, input allocated,
                  input cycles_charged, output ready);
endinterface

`default_nettype wire

>>> design/sacc_row_ram.sv
// One-port-write, one-port-read row memory with registered read data.
// Holds one set per row; depends on nothing.
`default_nettype none

module sacc_row_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 144
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output      logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/sacc_addr_split.sv
// Address split: offset/index/tag fields and set number modulo SETS.
// Reciprocal multiply over two stages; depends on sacc_pkg.
`default_nettype none

module sacc_addr_split
  import sacc_pkg::*;
#(
  parameter int SETS = 256
) (
  input  wire logic                                   clk,
  input  wire logic [ADDR_W-1:0]                      address,
  input  wire logic [3:0]                             offset_bits,
  input  wire logic [3:0]                             index_bits,
  output      logic [TAG_W-1:0]                       tag,
  output      logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] set_idx
);

  localparam int SW          = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SETS_W      = $clog2(SETS + 1);
  localparam int RECIP_SHIFT = 28;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = IDX_FLD_W + RECIP_W;
  localparam int QS_W        = IDX_FLD_W + SETS_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(SETS) - 64'd1) / 64'(SETS));

  logic [ADDR_W-1:0]    shifted;
  logic [15:0]          mask;
  logic [4:0]           tag_shift;
  logic [PROD_W-1:0]    prod;
  logic [QS_W-1:0]      qs;
  logic [IDX_FLD_W-1:0] rem;

  logic [IDX_FLD_W-1:0] x_r;
  logic [TAG_W-1:0]     tag_r;
  logic [IDX_FLD_W-1:0] q_r;

  assign shifted   = address >> offset_bits;
  assign mask      = (16'd1 << index_bits) - 16'd1;
  assign tag_shift = 5'(offset_bits) + 5'(index_bits);

  always_ff @(posedge clk) begin
    x_r   <= shifted[IDX_FLD_W-1:0] & mask[IDX_FLD_W-1:0];
    tag_r <= TAG_W'(address >> tag_shift);
  end

  assign prod = PROD_W'(x_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    q_r <= prod[RECIP_SHIFT +: IDX_FLD_W];
  end

  assign qs      = QS_W'(q_r) * QS_W'(SETS);
  assign rem     = x_r - qs[IDX_FLD_W-1:0];
  assign set_idx = rem[SW-1:0];
  assign tag     = tag_r;

endmodule

`default_nettype wire

>>> design/sacc_way_scan.sv
// Way scan unit: one way per beat, tag compare, first invalid, oldest way.
// Depends on sacc_pkg.
`default_nettype none

module sacc_way_scan
  import sacc_pkg::*;
#(
  parameter int WAYS = 4
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   clear,
  input  wire logic                                   step,
  input  wire logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] way_idx,
  input  wire logic                                   way_valid,
  input  wire logic [TAG_W-1:0]                       way_tag,
  input  wire logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] way_age,
  input  wire logic [TAG_W-1:0]                       look_tag,
  output      logic                                   hit,
  output      logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] hit_way,
  output      logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] victim_way
);

  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic          hit_r;
  logic [WW-1:0] hit_way_r;
  logic          inv_r;
  logic [WW-1:0] inv_way_r;
  logic [WW-1:0] max_way_r;
  logic [WW-1:0] max_age_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      hit_r     <= 1'b0;
      inv_r     <= 1'b0;
      max_way_r <= '0;
      max_age_r <= '0;
    end else if (step) begin
      if (!hit_r && way_valid && way_tag == look_tag) begin
        hit_r <= 1'b1;
      end
      if (!inv_r && !way_valid) begin
        inv_r <= 1'b1;
      end
      if (way_age > max_age_r) begin
        max_age_r <= way_age;
        max_way_r <= way_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && !hit_r && way_valid && way_tag == look_tag) begin
      hit_way_r <= way_idx;
    end
    if (step && !inv_r && !way_valid) begin
      inv_way_r <= way_idx;
    end
  end

  assign hit        = hit_r;
  assign hit_way    = hit_way_r;
  assign victim_way = inv_r ? inv_way_r : max_way_r;

endmodule

`default_nettype wire

>>> design/set_associative_cache_controller_unit.sv
// Set-associative cache controller (tag store), LRU or FIFO, write-back or through.
// An accepted beat passes the split, divide, modulo, scan and update states; the
// update waits while a held result is not taken. A new beat is taken in idle only.
// The way scan unit visits one way a cycle. Reset: synchronous; a clearing pass
// zeroes every set row, no input beat is taken meanwhile (configuration writes are).
`default_nettype none

module set_associative_cache_controller_unit
  import sacc_pkg::*;
#(
  parameter int SETS = 256,
  parameter int WAYS = 4
) (
  input wire logic   clk,
  input wire logic   rst_n,
  sacc_cfg_if.sink   cfg_wr,
  sacc_req_if.sink   in_req,
  sacc_rsp_if.source out_rsp
);

  `include "set_associative_cache_controller_unit_macros.svh"

  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AW = WW;
  localparam int NW = $clog2(WAYS + 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SPLIT  = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_MOD    = 3'd4;
  localparam logic [2:0] ST_SCAN   = 3'd5;
  localparam logic [2:0] ST_UPDATE = 3'd6;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic             dirty;
    logic [AW-1:0]    age;
  } way_t;

  typedef way_t [WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  cfg_t             cfg_r;
  logic [2:0]       state_r, state_nxt;
  logic [SW-1:0]    clr_r, clr_nxt;
  logic [WW-1:0]    wc_r, wc_nxt;
  logic             cmd_r;
  logic [ADDR_W-1:0] addr_r;
  logic [NW-1:0]    nways_r;
  logic [SW-1:0]    set_r;
  logic             out_valid_r, out_valid_nxt;
  logic             hit_r, evict_r, alloc_r;
  logic [CYC_W-1:0] cyc_r;

  logic [3:0]       ob_c;
  logic [NW-1:0]    nways_c;
  logic [NW-1:0]    nw1;
  logic [CYC_W-1:0] blk;
  logic             accept;
  logic             load_out;

  logic [TAG_W-1:0] look_tag;
  logic [SW-1:0]    set_c;

  logic             wr_en, rd_en;
  logic [SW-1:0]    wr_addr;
  logic [ROW_W-1:0] wr_data, rd_data;
  row_t             row, row_new;
  way_t             cur_way;

  logic             scan_clear, scan_step;
  logic             s_hit;
  logic [WW-1:0]    s_hit_way, s_victim;
  logic [AW-1:0]    e_age;
  logic             store, wt;
  logic             hit_c, evict_c, alloc_c;
  logic [CYC_W-1:0] cyc_c;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.reg_index)
        CFG_OFFSET_BITS:   cfg_r.offset_bits        <= cfg_wr.data;
        CFG_INDEX_BITS:    cfg_r.index_bits         <= cfg_wr.data;
        CFG_WAYS_IN_USE:   cfg_r.ways_in_use        <= cfg_wr.data[2:0];
        CFG_LRU_MODE:      cfg_r.lru_mode           <= cfg_wr.data[0];
        CFG_WRITE_THROUGH: cfg_r.write_through_mode <= cfg_wr.data[0];
        CFG_ALLOC_ON_WR:   cfg_r.allocate_on_write  <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  assign ob_c = (cfg_r.offset_bits > OFFSET_MAX) ? OFFSET_MAX : cfg_r.offset_bits;
  assign nways_c = (cfg_r.ways_in_use == 3'd0) ? NW'(1) :
                   (int'(cfg_r.ways_in_use) > WAYS) ? NW'(WAYS) : NW'(cfg_r.ways_in_use);
  assign nw1   = nways_r - NW'(1);
  assign blk   = CYC_W'(BLOCK_UNIT) << ob_c;
  assign store = (cmd_r == CMD_STORE);
  assign wt    = cfg_r.write_through_mode;

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_req.command;
      addr_r  <= in_req.address;
      nways_r <= nways_c;
    end
  end

  sacc_addr_split #(.SETS(SETS)) u_split (
    .clk         (clk),
    .address     (addr_r),
    .offset_bits (ob_c),
    .index_bits  (cfg_r.index_bits),
    .tag         (look_tag),
    .set_idx     (set_c)
  );

  sacc_row_ram #(.DEPTH(SETS), .WIDTH(ROW_W)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (set_c),
    .rd_data (rd_data)
  );

  assign row     = row_t'(rd_data);
  assign cur_way = row[wc_r];

  sacc_way_scan #(.WAYS(WAYS)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (scan_clear),
    .step       (scan_step),
    .way_idx    (wc_r),
    .way_valid  (cur_way.valid),
    .way_tag    (cur_way.tag),
    .way_age    (cur_way.age),
    .look_tag   (look_tag),
    .hit        (s_hit),
    .hit_way    (s_hit_way),
    .victim_way (s_victim)
  );

  always_ff @(posedge clk) begin
    if (state_r == ST_MOD) begin
      set_r <= set_c;
    end
  end

  always_comb begin
    row_new = row;
    e_age   = row[s_hit_way].age;
    hit_c   = 1'b0;
    evict_c = 1'b0;
    alloc_c = 1'b0;
    cyc_c   = '0;
    if (s_hit) begin
      hit_c = 1'b1;
      if (!store) begin
        cyc_c = CYC_W'(1);
      end else if (wt) begin
        cyc_c = CYC_W'(MEM_CYCLES) + CYC_W'(cfg_r.allocate_on_write);
      end else begin
        row_new[s_hit_way].dirty = 1'b1;
        cyc_c = CYC_W'(1);
      end
      if (cfg_r.lru_mode) begin
        for (int w = 0; w < WAYS; w++) begin
          if (NW'(w) < nways_r && row[w].valid && row[w].age < e_age &&
              NW'(row[w].age) < nw1) begin
            row_new[w].age = row[w].age + AW'(1);
          end
        end
        row_new[s_hit_way].age = '0;
      end
    end else if (store && !cfg_r.allocate_on_write) begin
      cyc_c = CYC_W'(MEM_CYCLES);
    end else begin
      alloc_c = 1'b1;
      evict_c = row[s_victim].valid && row[s_victim].dirty && !wt;
      for (int w = 0; w < WAYS; w++) begin
        if (NW'(w) < nways_r && WW'(w) != s_victim && row[w].valid &&
            NW'(row[w].age) < nw1) begin
          row_new[w].age = row[w].age + AW'(1);
        end
      end
      row_new[s_victim].tag   = look_tag;
      row_new[s_victim].valid = 1'b1;
      row_new[s_victim].dirty = store && !wt;
      row_new[s_victim].age   = '0;
      cyc_c = (evict_c ? blk : '0) + blk + CYC_W'(1) + (store && wt ? CYC_W'(MEM_CYCLES) : '0);
    end
  end

  always_comb begin
    state_nxt  = state_r;
    clr_nxt    = clr_r;
    wc_nxt     = wc_r;
    wr_en      = 1'b0;
    wr_addr    = set_r;
    wr_data    = row_new;
    rd_en      = 1'b0;
    scan_clear = 1'b0;
    scan_step  = 1'b0;
    load_out   = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + SW'(1);
        if (clr_r == SW'(SETS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_MOD;
      ST_MOD: begin
        rd_en      = 1'b1;
        scan_clear = 1'b1;
        wc_nxt     = '0;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        scan_step = 1'b1;
        wc_nxt    = wc_r + WW'(1);
        if (NW'(wc_r) + NW'(1) == nways_r) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid_r || out_rsp.ready) begin
          wr_en     = 1'b1;
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      wc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      wc_r        <= wc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      hit_r   <= hit_c;
      evict_r <= evict_c;
      alloc_r <= alloc_c;
      cyc_r   <= cyc_c;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.hit            = hit_r;
  assign out_rsp.dirty_evicted  = evict_r;
  assign out_rsp.allocated      = alloc_r;
  assign out_rsp.cycles_charged = cyc_r;

  `SACC_ASSERT_NEXT(a_accept_starts, accept, state_r == ST_SPLIT, "accepted beat did not start split")
  `SACC_ASSERT_NOW(a_hit_no_fill, out_rsp.valid && out_rsp.hit, !out_rsp.allocated && !out_rsp.dirty_evicted, "hit reported a fill or eviction")
  `SACC_ASSERT_NOW(a_evict_fill, out_rsp.valid && out_rsp.dirty_evicted, out_rsp.allocated, "eviction without fill")
  `SACC_ASSERT_NEXT(a_update_write, state_r == ST_UPDATE && load_out, out_rsp.valid, "result not presented after update")

endmodule

`default_nettype wire

>>> test/tb_set_associative_cache_controller_unit.sv
// Self-checking bench for the set-associative cache controller: loads and stores through
// the request channel, each result checked against a tag-store scoreboard with LRU/FIFO.
// Depends on sacc_pkg and the sacc_cfg_if, sacc_req_if and sacc_rsp_if interfaces.
`default_nettype none

module tb_set_associative_cache_controller_unit;
  import sacc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETS = 256;
  localparam int WAYS = 4;
  localparam int SETTLE = 5 + WAYS;

  typedef struct packed {
    logic             hit;
    logic             dirty_evicted;
    logic             allocated;
    logic [CYC_W-1:0] cycles;
  } access_outcome_t;

  class tag_store_scoreboard;
    logic [TAG_W-1:0] tags [SETS*WAYS];
    bit               valid [SETS*WAYS];
    bit               dirty [SETS*WAYS];
    logic [1:0]       age [SETS*WAYS];
    cfg_t             conf;
    access_outcome_t  awaited [$];
    int unsigned      errors;

    function new();
      for (int k = 0; k < SETS*WAYS; k++) begin
        tags[k] = '0;
        valid[k] = 1'b0;
        dirty[k] = 1'b0;
        age[k] = '0;
      end
      conf = CFG_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_OFFSET_BITS:   conf.offset_bits = data;
        CFG_INDEX_BITS:    conf.index_bits = data;
        CFG_WAYS_IN_USE:   conf.ways_in_use = data[2:0];
        CFG_LRU_MODE:      conf.lru_mode = data[0];
        CFG_WRITE_THROUGH: conf.write_through_mode = data[0];
        CFG_ALLOC_ON_WR:   conf.allocate_on_write = data[0];
        default: ;
      endcase
    endfunction

    function void age_ways(int unsigned base, int unsigned nways, int unsigned below);
      int unsigned e;
      for (int unsigned w = 0; w < nways; w++) begin
        e = base + w;
        if (valid[e] && age[e] < below && age[e] < nways - 1)
          age[e] = age[e] + 2'd1;
      end
    endfunction

    function void note_access(logic cmd, logic [ADDR_W-1:0] addr);
      int unsigned ob, ib, nways, blk, set_no, base, victim, e;
      logic [TAG_W-1:0] tag;
      int found;
      access_outcome_t o;
      ob = 32'((conf.offset_bits > OFFSET_MAX) ? OFFSET_MAX : conf.offset_bits);
      ib = 32'(conf.index_bits);
      nways = (conf.ways_in_use == 3'd0) ? 32'd1 : 32'(conf.ways_in_use);
      if (nways > WAYS)
        nways = WAYS;
      blk = (MEM_CYCLES << ob) / WORD_BYTES;
      set_no = ((addr >> ob) & ((32'd1 << ib) - 32'd1)) % SETS;
      tag = addr >> (ob + ib);
      base = set_no * WAYS;
      found = -1;
      o = '0;
      for (int unsigned w = 0; w < nways; w++)
        if (found < 0 && valid[base + w] && tags[base + w] == tag)
          found = int'(w);
      if (found >= 0) begin
        e = base + 32'(found);
        o.hit = 1'b1;
        if (cmd == CMD_LOAD) begin
          o.cycles = CYC_W'(1);
        end else if (conf.write_through_mode) begin
          o.cycles = CYC_W'(MEM_CYCLES) + CYC_W'(conf.allocate_on_write);
        end else begin
          dirty[e] = 1'b1;
          o.cycles = CYC_W'(1);
        end
        if (conf.lru_mode) begin
          age_ways(base, nways, 32'(age[e]));
          age[e] = '0;
        end
      end else if (cmd == CMD_STORE && !conf.allocate_on_write) begin
        o.cycles = CYC_W'(MEM_CYCLES);
      end else begin
        victim = nways;
        for (int unsigned w = 0; w < nways; w++)
          if (victim == nways && !valid[base + w])
            victim = w;
        if (victim == nways) begin
          victim = 0;
          for (int unsigned w = 1; w < nways; w++)
            if (age[base + w] > age[base + victim])
              victim = w;
        end
        e = base + victim;
        if (valid[e] && dirty[e] && !conf.write_through_mode) begin
          o.dirty_evicted = 1'b1;
          o.cycles = o.cycles + CYC_W'(blk);
        end
        valid[e] = 1'b0;
        age_ways(base, nways, 255);
        valid[e] = 1'b1;
        tags[e] = tag;
        age[e] = '0;
        dirty[e] = 1'b0;
        o.allocated = 1'b1;
        if (cmd == CMD_LOAD) begin
          o.cycles = o.cycles + CYC_W'(1) + CYC_W'(blk);
        end else if (conf.write_through_mode) begin
          o.cycles = o.cycles + CYC_W'(blk) + CYC_W'(MEM_CYCLES) + CYC_W'(1);
        end else begin
          dirty[e] = 1'b1;
          o.cycles = o.cycles + CYC_W'(blk) + CYC_W'(1);
        end
      end
      awaited.push_back(o);
    endfunction

    function void check_result(logic hit, logic evicted, logic alloc, logic [CYC_W-1:0] cyc);
      access_outcome_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result beat: hit %0d dirty_evicted %0d allocated %0d cycles %0d",
                 $time, hit, evicted, alloc, cyc);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (hit !== want.hit) begin
        $display("%0t: hit expected %0d actual %0d", $time, want.hit, hit);
        errors++;
      end
      if (evicted !== want.dirty_evicted) begin
        $display("%0t: dirty_evicted expected %0d actual %0d", $time, want.dirty_evicted, evicted);
        errors++;
      end
      if (alloc !== want.allocated) begin
        $display("%0t: allocated expected %0d actual %0d", $time, want.allocated, alloc);
        errors++;
      end
      if (cyc !== want.cycles) begin
        $display("%0t: cycles_charged expected %0d actual %0d", $time, want.cycles, cyc);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;

  sacc_cfg_if cfg_wr ();
  sacc_req_if in_req ();
  sacc_rsp_if out_rsp ();

  tag_store_scoreboard tag_board = new();

  set_associative_cache_controller_unit #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_wr  (cfg_wr),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_rsp.valid && out_rsp.ready)
      tag_board.check_result(out_rsp.hit, out_rsp.dirty_evicted, out_rsp.allocated,
                             out_rsp.cycles_charged);
    out_rsp.ready <= calm || ($urandom_range(0, 99) >= 10);
  end

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr.valid <= 1'b1;
    cfg_wr.reg_index <= idx;
    cfg_wr.data <= data;
    do @(posedge clk); while (cfg_wr.ready !== 1'b1);
    tag_board.write_reg(idx, data);
  endtask

  task automatic drain_then_configure(input cfg_t c);
    in_req.valid <= 1'b0;
    while (tag_board.awaited.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    put_reg(CFG_OFFSET_BITS, c.offset_bits);
    put_reg(CFG_INDEX_BITS, c.index_bits);
    put_reg(CFG_WAYS_IN_USE, {1'b0, c.ways_in_use});
    put_reg(CFG_LRU_MODE, {3'b000, c.lru_mode});
    put_reg(CFG_WRITE_THROUGH, {3'b000, c.write_through_mode});
    put_reg(CFG_ALLOC_ON_WR, {3'b000, c.allocate_on_write});
    cfg_wr.valid <= 1'b0;
  endtask

  task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr);
    in_req.valid <= 1'b1;
    in_req.command <= cmd;
    in_req.address <= addr;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    tag_board.note_access(cmd, addr);
  endtask

  // few tags over a few sets so that hits, fills and evictions all recur
  function automatic logic [ADDR_W-1:0] pick_address(input cfg_t c);
    int unsigned ob, ib;
    logic [ADDR_W-1:0] tagv, setv, off, addr;
    ob = 32'((c.offset_bits > OFFSET_MAX) ? OFFSET_MAX : c.offset_bits);
    ib = 32'(c.index_bits);
    tagv = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 5);
    case ($urandom_range(0, 3))
      0: setv = 32'd0;
      1: setv = 32'd1;
      2: setv = 32'd255;
      default: setv = 32'd256 + $urandom_range(0, 1);
    endcase
    off = $urandom() & ((32'd1 << ob) - 32'd1);
    addr = (tagv << (ob + ib)) | ((setv & ((32'd1 << ib) - 32'd1)) << ob) | off;
    if ($urandom_range(0, 9) == 0)
      addr = $urandom();
    return addr;
  endfunction

  function automatic cfg_t random_config();
    cfg_t c;
    c.offset_bits = 4'($urandom_range(0, 15));
    c.index_bits = 4'($urandom_range(0, 15));
    c.ways_in_use = 3'($urandom_range(0, 7));
    c.lru_mode = 1'($urandom_range(0, 1));
    c.write_through_mode = 1'($urandom_range(0, 1));
    c.allocate_on_write = 1'($urandom_range(0, 1));
    return c;
  endfunction

  initial begin
    cfg_t extremes [4];
    cfg_t phase_cfg;
    extremes[0] = '{4'd2, 4'd0, 3'd1, 1'b1, 1'b0, 1'b1};
    extremes[1] = '{4'd12, 4'd8, 3'd4, 1'b0, 1'b1, 1'b0};
    extremes[2] = '{4'd0, 4'd15, 3'd7, 1'b1, 1'b0, 1'b0};
    extremes[3] = '{4'd15, 4'd3, 3'd0, 1'b0, 1'b0, 1'b1};
    calm = 1'b0;
    rst_n <= 1'b0;
    cfg_wr.valid <= 1'b0;
    cfg_wr.reg_index <= '0;
    cfg_wr.data <= '0;
    in_req.valid <= 1'b0;
    in_req.command <= CMD_LOAD;
    in_req.address <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    drain_then_configure(CFG_RESET);
    send_access(CMD_LOAD, 32'h0000_0000);
    send_access(CMD_LOAD, 32'h0000_0000);
    send_access(CMD_STORE, 32'h0000_0004);
    send_access(CMD_LOAD, 32'hFFFF_FFFF);
    send_access(CMD_STORE, 32'hFFFF_FFF0);
    send_access(CMD_LOAD, 32'h0000_1000);
    send_access(CMD_STORE, 32'h0000_2000);
    send_access(CMD_LOAD, 32'h0000_3000);
    send_access(CMD_LOAD, 32'h0000_4000);
    send_access(CMD_STORE, 32'h0000_4000);
    send_access(CMD_LOAD, 32'h0000_1000);

    // oversized offset and index, no ways, FIFO, write-through, write-around
    drain_then_configure('{4'd15, 4'd12, 3'd0, 1'b0, 1'b1, 1'b0});
    send_access(CMD_STORE, 32'h1234_5678);
    send_access(CMD_LOAD, 32'h1234_5678);
    send_access(CMD_STORE, 32'h1234_5000);
    send_access(CMD_LOAD, 32'h0000_0000);
    send_access(CMD_LOAD, 32'h0010_0000);
    send_access(CMD_STORE, 32'hFFFF_FFFF);
    send_access(CMD_LOAD, 32'hFFFF_FFFF);

    for (int p = 0; p < 12; p++) begin
      phase_cfg = (p < 4) ? extremes[p] : random_config();
      drain_then_configure(phase_cfg);
      calm = (p == 6);
      for (int i = 0; i < 140; i++) begin
        if (!calm && $urandom_range(0, 99) < 10) begin
          in_req.valid <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        send_access(1'($urandom_range(0, 1)), pick_address(phase_cfg));
      end
    end
    calm = 1'b0;

    in_req.valid <= 1'b0;
    while (tag_board.awaited.size() != 0)
      @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);
    if (tag_board.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
